FILE: hdl/gbn_pkg.sv
package gbn_pkg;

  // Window and message limits
  localparam int unsigned WINDOW      = 4;
  localparam int unsigned CHUNK_LIMIT = 1024;

  // Field widths
  localparam int unsigned SEQ_W   = 11;
  localparam int unsigned BASE_W  = SEQ_W + 1;
  localparam int unsigned TIMER_W = 20;
  localparam int unsigned RETRY_W = 3;
  localparam int unsigned CFG_W   = TIMER_W;
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);

  // Register reset values
  localparam int unsigned TIMEOUT_RESET = 100000;
  localparam int unsigned RETRIES_RESET = 5;

  // Command queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EV_SEND = 2'd0,
    EV_DONE = 2'd1,
    EV_FAIL = 2'd2
  } event_e;

  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_RETRIES = 1'b1
  } cfg_reg_e;

  // One queued command: a run of sends, or a single done / failed report
  typedef struct packed {
    event_e             ev;
    logic [SEQ_W-1:0]   first;  // 0-based index of first chunk in the run
    logic [CNT_W-1:0]   cnt;    // results in this command
    logic [SEQ_W-1:0]   total;
  } cmd_t;

endpackage

FILE: hdl/gbn_if.sv
interface gbn_in_if;
  import gbn_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [SEQ_W-1:0] chunk_count;
  logic [SEQ_W-1:0] ack_number;

  modport source (output valid, kind, chunk_count, ack_number, input ready);
  modport sink   (input valid, kind, chunk_count, ack_number, output ready);
endinterface

interface gbn_out_if;
  import gbn_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       event_res;
  logic [SEQ_W-1:0] seq_number;
  logic [SEQ_W-1:0] total;
  logic             last;

  modport source (output valid, event_res, seq_number, total, last, input ready);
  modport sink   (input valid, event_res, seq_number, total, last, output ready);
endinterface

FILE: hdl/gbn_front.sv
module gbn_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gbn_in_if.sink                    req_i,
  input  logic                      cfg_we_i,
  input  gbn_pkg::cfg_reg_e         cfg_idx_i,
  input  logic [gbn_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output gbn_pkg::cmd_t             cmd_o
);
  import gbn_pkg::*;

  logic [TIMER_W-1:0] timeout_q;
  logic [RETRY_W-1:0] retries_q;
  logic [SEQ_W-1:0]   base_q, base_d;
  logic [SEQ_W-1:0]   nts_q, nts_d;
  logic [SEQ_W-1:0]   total_q, total_d;
  logic [RETRY_W-1:0] retry_q, retry_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic               busy_q, busy_d;

  logic               accept;
  logic               do_send, do_fin;
  event_e             fin_ev;
  logic [SEQ_W-1:0]   s_from;
  logic [SEQ_W-1:0]   cnt_clamp, ack_clamp;
  logic [TIMER_W-1:0] timer_inc, limit;
  logic [BASE_W-1:0]  room, left, n_wide;
  logic [CNT_W-1:0]   n_send;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    base_d    = base_q;
    nts_d     = nts_q;
    total_d   = total_q;
    retry_d   = retry_q;
    timer_d   = timer_q;
    busy_d    = busy_q;
    do_send   = 1'b0;
    do_fin    = 1'b0;
    fin_ev    = EV_DONE;
    s_from    = nts_q;
    cnt_clamp = (req_i.chunk_count > SEQ_W'(CHUNK_LIMIT)) ? SEQ_W'(CHUNK_LIMIT)
                                                           : req_i.chunk_count;
    ack_clamp = (req_i.ack_number > total_q) ? total_q : req_i.ack_number;
    timer_inc = (timer_q == '1) ? timer_q : timer_q + TIMER_W'(1);
    limit     = (timeout_q == '0) ? TIMER_W'(1) : timeout_q;

    if (accept) begin
      case (req_i.kind)
        KIND_START: begin
          total_d = cnt_clamp;
          base_d  = '0;
          nts_d   = '0;
          retry_d = '0;
          timer_d = '0;
          busy_d  = 1'b1;
          if (cnt_clamp == '0) begin
            do_fin = 1'b1;
            busy_d = 1'b0;
          end else begin
            do_send = 1'b1;
            s_from  = '0;
          end
        end
        KIND_ACK: begin
          if (busy_q) begin
            timer_d = '0;
            if (ack_clamp > base_q) begin
              base_d  = ack_clamp;
              retry_d = '0;
              if (ack_clamp >= total_q) begin
                do_fin = 1'b1;
                busy_d = 1'b0;
              end else begin
                do_send = 1'b1;
                s_from  = (nts_q < ack_clamp) ? ack_clamp : nts_q;
              end
            end
          end
        end
        KIND_TICK: begin
          if (busy_q) begin
            timer_d = timer_inc;
            if (timer_inc >= limit) begin
              timer_d = '0;
              if (retry_q < retries_q) begin
                retry_d = retry_q + RETRY_W'(1);
                do_send = 1'b1;
                s_from  = base_q;
              end else begin
                do_fin = 1'b1;
                fin_ev = EV_FAIL;
                busy_d = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // chunks that fit: bounded by the window edge and by the message end
    room   = {1'b0, base_d} + BASE_W'(WINDOW) - {1'b0, s_from};
    left   = {1'b0, total_d} - {1'b0, s_from};
    n_wide = (room < left) ? room : left;
    if (n_wide > BASE_W'(WINDOW)) begin
      n_wide = BASE_W'(WINDOW);
    end
    n_send = n_wide[CNT_W-1:0];

    push_o       = 1'b0;
    cmd_o.ev     = EV_SEND;
    cmd_o.first  = s_from;
    cmd_o.cnt    = n_send;
    cmd_o.total  = total_d;
    if (do_send) begin
      nts_d  = s_from + SEQ_W'(n_send);
      push_o = (n_send != '0);
    end
    if (do_fin) begin
      push_o      = 1'b1;
      cmd_o.ev    = fin_ev;
      cmd_o.first = '0;
      cmd_o.cnt   = CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMER_W'(TIMEOUT_RESET);
      retries_q <= RETRY_W'(RETRIES_RESET);
      base_q    <= '0;
      nts_q     <= '0;
      total_q   <= '0;
      retry_q   <= '0;
      timer_q   <= '0;
      busy_q    <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_TIMEOUT) begin
        timeout_q <= cfg_data_i[TIMER_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_RETRIES) begin
        retries_q <= cfg_data_i[RETRY_W-1:0];
      end
      base_q  <= base_d;
      nts_q   <= nts_d;
      total_q <= total_d;
      retry_q <= retry_d;
      timer_q <= timer_d;
      busy_q  <= busy_d;
    end
  end

  // never more than a window ahead of the base
  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, nts_q} <= {1'b0, base_q} + BASE_W'(WINDOW)))
    else $error("next pointer beyond window");

  a_busy_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (base_q < total_q) && (nts_q <= total_q))
    else $error("busy with base at or past total");

  a_send_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.ev == EV_SEND) |->
      (cmd_o.cnt != '0) && (cmd_o.cnt <= CNT_W'(WINDOW)) && !q_full_i)
    else $error("bad send run pushed");

endmodule

FILE: hdl/gbn_cmd_fifo.sv
module gbn_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbn_pkg::cmd_t din_i,
  output logic          full_o,
  input  logic          pop_i,
  output gbn_pkg::cmd_t head_o,
  output logic          empty_o
);
  import gbn_pkg::*;

  cmd_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [FCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FCNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + FCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/gbn_back.sv
module gbn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gbn_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  gbn_out_if.source     res_o
);
  import gbn_pkg::*;

  logic [CNT_W-1:0] off_q, off_d;
  logic             is_send, last, take;

  assign is_send = (head_i.ev == EV_SEND);
  assign last    = !is_send || (off_q == head_i.cnt - CNT_W'(1));

  assign res_o.valid      = !empty_i;
  assign res_o.event_res  = head_i.ev;
  assign res_o.seq_number = is_send ? head_i.first + SEQ_W'(off_q) + SEQ_W'(1) : '0;
  assign res_o.total      = head_i.total;
  assign res_o.last       = last;

  assign take  = res_o.valid && res_o.ready;
  assign pop_o = take && last;

  always_comb begin
    off_d = off_q;
    if (take) begin
      off_d = last ? '0 : off_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else begin
      off_q <= off_d;
    end
  end

  a_send_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && is_send) |->
      (res_o.seq_number != '0) && (res_o.seq_number <= res_o.total))
    else $error("send outside message");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last) |=>
      res_o.valid && (res_o.seq_number == $past(res_o.seq_number) + SEQ_W'(1)))
    else $error("send run not consecutive");

  a_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !is_send) |-> res_o.last && (res_o.seq_number == '0) &&
      (off_q == '0))
    else $error("malformed done or failed report");

endmodule

FILE: hdl/go_back_n_sender.sv
// Go-back-N sender window controller. Requests on req_i are start (chunk count,
// saturated at CHUNK_LIMIT), cumulative ack, or timer tick; results on res_o are
// send commands (1-based sequence number and total), or a single done / failed
// report, with last marking the final result of each request. The front stage
// takes a request whenever the command queue (FIFO_DEPTH entries) has room,
// updates the window state and queues a run of up to WINDOW sends, one report
// or nothing; the back stage plays each command out at one result per cycle
// while res_o is ready. With a ready sink the sustained rate is set by the back
// stage. Configuration (timeout_ticks at index 0, max_retries at index 1)
// is written through cfg_we_i / cfg_idx_i / cfg_data_i and must only
// change while the block is idle; a timeout of zero behaves as one.
module go_back_n_sender (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gbn_in_if.sink                    req_i,
  gbn_out_if.source                 res_o,
  input  logic                      cfg_we_i,
  input  gbn_pkg::cfg_reg_e         cfg_idx_i,
  input  logic [gbn_pkg::CFG_W-1:0] cfg_data_i
);
  import gbn_pkg::*;

  // front -> queue
  logic push;
  cmd_t cmd;
  logic q_full;

  // queue -> back
  cmd_t head;
  logic q_empty;
  logic pop;

  // window state, timer, retries and config registers
  gbn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  // decouples request acceptance from result back-pressure
  gbn_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  // expands a command into results, one per cycle while res_o is ready
  gbn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
